// ----- rtl/eia_pkg.sv -----
package eia_pkg;

  // Sizes of the ID space and of one component mask.
  localparam int ENTITY_COUNT = 1024;
  localparam int MASK_W       = 32;
  localparam int ENT_W        = $clog2(ENTITY_COUNT);
  localparam int CNT_W        = $clog2(ENTITY_COUNT + 1);
  localparam int OP_W         = 3;
  localparam int STATUS_W     = 2;

  // Depth of the command queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  // Operation codes as they arrive on the input port.
  localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
  localparam logic [OP_W-1:0] OP_DESTROY = 3'd1;
  localparam logic [OP_W-1:0] OP_SET     = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;

  // Operation class decided by the front.
  typedef enum logic [2:0] {
    K_CREATE,
    K_DESTROY,
    K_SET,
    K_CLEAR,
    K_READ,
    K_NOP
  } kind_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_LIVE = 2'd2
  } status_t;

  // States of the back end sequencer.
  typedef enum logic [1:0] {
    B_IDLE,
    B_TBL,
    B_EXEC
  } bstate_t;

  // One classified command as it waits in the queue.
  typedef struct packed {
    kind_t              kind;
    logic               ent_ok;
    logic [ENT_W-1:0]   ent;
    logic [MASK_W-1:0]  bits;
  } cmd_t;

endpackage

// ----- rtl/eia_front.sv -----
module eia_front import eia_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [ENT_W-1:0]  in_entity,
  input  logic [MASK_W-1:0] in_mask_bits,
  input  logic              busy,
  output logic              q_valid,
  output cmd_t              q_cmd,
  input  logic              q_pop
);

  cmd_t             q_mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r;
  logic [Q_AW-1:0]  rd_ptr_r;
  logic [QC_W-1:0]  cnt_r;
  logic             push;
  cmd_t             cls;

  // Take a word whenever the queue has room and the tables are ready.
  assign in_stall = busy || (cnt_r == QC_W'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_cmd    = q_mem_r[rd_ptr_r];

  // Classify the incoming word.
  always_comb begin
    cls.ent    = in_entity;
    cls.bits   = in_mask_bits;
    cls.ent_ok = ({1'b0, in_entity} < CNT_W'(ENTITY_COUNT));
    case (in_operation)
      OP_CREATE:  cls.kind = K_CREATE;
      OP_DESTROY: cls.kind = K_DESTROY;
      OP_SET:     cls.kind = K_SET;
      OP_CLEAR:   cls.kind = K_CLEAR;
      OP_READ:    cls.kind = K_READ;
      default:    cls.kind = K_NOP;
    endcase
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (q_pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // The fill count never exceeds the queue depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QC_W'(Q_DEPTH))
    else $error("queue count over depth");

  // A pop only happens when a command is waiting.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // No word is taken while the tables are being cleared.
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !push)
    else $error("word accepted during clearing pass");

endmodule

// ----- rtl/eia_back.sv -----
module eia_back import eia_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  cmd_t                q_cmd,
  output logic                q_pop,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CNT_W-1:0]    out_result_entity,
  output logic [MASK_W-1:0]   out_mask_out,
  output logic [STATUS_W-1:0] out_status,
  output logic [CNT_W-1:0]    out_live_count,
  output logic [CNT_W-1:0]    out_free_count
);

  // Free ID ring and entity table ({live, mask} per entity).
  logic [ENT_W-1:0]  ring_mem [ENTITY_COUNT];
  logic [MASK_W:0]   tbl_mem  [ENTITY_COUNT];

  bstate_t           state_r, state_nxt;
  cmd_t              cmd_r;
  logic [ENT_W-1:0]  head_r, head_nxt;
  logic [ENT_W-1:0]  tail_r, tail_nxt;
  logic              wrap_r, wrap_nxt;
  logic [CNT_W-1:0]  live_r, live_nxt;
  logic              clearing_r;
  logic [ENT_W-1:0]  clr_idx_r;
  logic [ENT_W-1:0]  ring_rd_r;
  logic              ring_def_r;
  logic [ENT_W-1:0]  id_r;
  logic [MASK_W:0]   tbl_rd_r;

  logic              ring_rd_en;
  logic              ring_we;
  logic              tbl_rd_en;
  logic [ENT_W-1:0]  tbl_ra;
  logic              ex_we;
  logic [ENT_W-1:0]  ex_wa;
  logic [MASK_W:0]   ex_wd;
  logic              tbl_we;
  logic [ENT_W-1:0]  tbl_wa;
  logic [MASK_W:0]   tbl_wd;
  logic [ENT_W-1:0]  id_sel;
  logic              load_out;
  logic [CNT_W-1:0]  res_ent;
  logic [MASK_W-1:0] res_mask;
  status_t           res_status;
  logic [MASK_W-1:0] cur_mask;
  logic              cur_live;

  logic                out_valid_r;
  logic [CNT_W-1:0]    out_ent_r;
  logic [MASK_W-1:0]   out_mask_r;
  status_t             out_status_r;
  logic [CNT_W-1:0]    out_live_r;
  logic [CNT_W-1:0]    out_free_r;

  assign busy     = clearing_r;
  assign cur_mask = tbl_rd_r[MASK_W-1:0];
  assign cur_live = tbl_rd_r[MASK_W];

  // A ring slot that the tail has not reached yet still holds its own index.
  assign id_sel = ring_def_r ? head_r : ring_rd_r;

  // Sequencer: next state, memory controls and the result of one command.
  always_comb begin
    state_nxt  = state_r;
    q_pop      = 1'b0;
    ring_rd_en = 1'b0;
    tbl_rd_en  = 1'b0;
    tbl_ra     = cmd_r.ent;
    ex_we      = 1'b0;
    ex_wa      = cmd_r.ent;
    ex_wd      = '0;
    ring_we    = 1'b0;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    wrap_nxt   = wrap_r;
    live_nxt   = live_r;
    load_out   = 1'b0;
    res_ent    = '0;
    res_mask   = '0;
    res_status = ST_OK;
    case (state_r)
      B_IDLE: begin
        if (q_valid && !clearing_r) begin
          q_pop      = 1'b1;
          ring_rd_en = 1'b1;
          state_nxt  = B_TBL;
        end
      end
      B_TBL: begin
        tbl_rd_en = 1'b1;
        if (cmd_r.kind == K_CREATE) begin
          tbl_ra = id_sel;
        end
        state_nxt = B_EXEC;
      end
      B_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = B_IDLE;
          case (cmd_r.kind)
            K_CREATE: begin
              if (live_r == CNT_W'(ENTITY_COUNT)) begin
                res_ent    = CNT_W'(ENTITY_COUNT);
                res_status = ST_FULL;
              end else begin
                res_ent  = CNT_W'(id_r);
                res_mask = cur_mask;
                ex_we    = 1'b1;
                ex_wa    = id_r;
                ex_wd    = {1'b1, cur_mask};
                head_nxt = (head_r == ENT_W'(ENTITY_COUNT - 1)) ? '0 : head_r + 1'b1;
                live_nxt = live_r + 1'b1;
              end
            end
            K_DESTROY: begin
              if (!cmd_r.ent_ok) begin
                res_status = ST_NOT_LIVE;
              end else if (!cur_live) begin
                res_status = ST_NOT_LIVE;
                res_mask   = cur_mask;
              end else begin
                ex_we   = 1'b1;
                ex_wd   = '0;
                ring_we = 1'b1;
                if (tail_r == ENT_W'(ENTITY_COUNT - 1)) begin
                  tail_nxt = '0;
                  wrap_nxt = 1'b1;
                end else begin
                  tail_nxt = tail_r + 1'b1;
                end
                if (live_r != '0) begin
                  live_nxt = live_r - 1'b1;
                end
              end
            end
            K_SET: begin
              if (cmd_r.ent_ok) begin
                res_mask = cur_mask | cmd_r.bits;
                ex_we    = 1'b1;
                ex_wd    = {cur_live, res_mask};
              end
            end
            K_CLEAR: begin
              if (cmd_r.ent_ok) begin
                res_mask = cur_mask & ~cmd_r.bits;
                ex_we    = 1'b1;
                ex_wd    = {cur_live, res_mask};
              end
            end
            K_READ: begin
              if (cmd_r.ent_ok) begin
                res_mask = cur_mask;
              end
            end
            default: begin
              res_mask = '0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // The clearing pass owns the table write port after reset.
  assign tbl_we = clearing_r || ex_we;
  assign tbl_wa = clearing_r ? clr_idx_r : ex_wa;
  assign tbl_wd = clearing_r ? '0 : ex_wd;

  // Ring memory: read at the head, written at the tail.
  always_ff @(posedge clk) begin
    if (ring_rd_en) begin
      ring_rd_r  <= ring_mem[head_r];
      ring_def_r <= !(wrap_r || (head_r < tail_r));
    end
    if (ring_we) begin
      ring_mem[tail_r] <= cmd_r.ent;
    end
  end

  // Entity table memory.
  always_ff @(posedge clk) begin
    if (tbl_rd_en) begin
      tbl_rd_r <= tbl_mem[tbl_ra];
    end
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
  end

  // Command and allocated ID holding registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    if (state_r == B_TBL) begin
      id_r <= id_sel;
    end
  end

  // Control state, counters and the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      wrap_r     <= 1'b0;
      live_r     <= '0;
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      wrap_r  <= wrap_nxt;
      live_r  <= live_nxt;
      if (clearing_r) begin
        if (clr_idx_r == ENT_W'(ENTITY_COUNT - 1)) begin
          clearing_r <= 1'b0;
        end
        clr_idx_r <= clr_idx_r + 1'b1;
      end
    end
  end

  // Output register holds one result word until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ent_r    <= res_ent;
      out_mask_r   <= res_mask;
      out_status_r <= res_status;
      out_live_r   <= live_nxt;
      out_free_r   <= CNT_W'(ENTITY_COUNT) - live_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_entity = out_ent_r;
  assign out_mask_out      = out_mask_r;
  assign out_status        = out_status_r;
  assign out_live_count    = out_live_r;
  assign out_free_count    = out_free_r;

  // The live count never exceeds the ID space.
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CNT_W'(ENTITY_COUNT))
    else $error("live count over entity count");

  // No command is started while the clearing pass runs.
  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> (state_r == B_IDLE) && !q_pop)
    else $error("command started during clearing pass");

  // A create on a full pool reports no free entity.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && cmd_r.kind == K_CREATE && live_r == CNT_W'(ENTITY_COUNT))
    |=> out_status_r == ST_FULL && out_ent_r == CNT_W'(ENTITY_COUNT))
    else $error("full create not reported");

  // Free and live counts of a result always add up to the pool size.
  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (out_live_r + out_free_r) == CNT_W'(ENTITY_COUNT))
    else $error("live and free counts disagree");

endmodule

// ----- rtl/entity_id_allocator_top.sv -----
// Channel   Direction  Handshake            Word
// in_       input      in_valid/in_stall    operation, entity, mask_bits
// out_      output     out_valid/out_stall  result_entity, mask_out, status,
//                                           live_count, free_count
//
// In the back end each command passes a ring read at the head, an entity table
// read, then execute and write back; a create must finish its ring read before
// its dependent table lookup.
// After reset a clearing pass zeroes the entity table, with in_stall high.
// A two-word queue lets the input side run ahead while a result waits on out_stall.
// A stalled result holds in the output register; the back end waits in execute.
module entity_id_allocator_top import eia_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [ENT_W-1:0]    in_entity,
  input  logic [MASK_W-1:0]   in_mask_bits,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CNT_W-1:0]    out_result_entity,
  output logic [MASK_W-1:0]   out_mask_out,
  output logic [STATUS_W-1:0] out_status,
  output logic [CNT_W-1:0]    out_live_count,
  output logic [CNT_W-1:0]    out_free_count
);

  logic busy;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // Front end: takes and classifies words into the command queue.
  eia_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_entity    (in_entity),
    .in_mask_bits (in_mask_bits),
    .busy         (busy),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop)
  );

  // Back end: free ring, entity table and result register.
  eia_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .q_pop             (q_pop),
    .busy              (busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_entity (out_result_entity),
    .out_mask_out      (out_mask_out),
    .out_status        (out_status),
    .out_live_count    (out_live_count),
    .out_free_count    (out_free_count)
  );

endmodule

// ----- verif/entity_id_allocator_top_test.sv -----
`timescale 1ns / 1ps

module entity_id_allocator_top_test;
  import eia_pkg::*;

  // Operation codes that the block has no meaning for.
  localparam logic [OP_W-1:0] OP_RESV_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_RESV_LAST  = 3'd7;

  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 250;

  // One result word as the block should report it.
  typedef struct {
    logic [CNT_W-1:0]  result_entity;
    logic [MASK_W-1:0] mask;
    status_t           status;
    logic [CNT_W-1:0]  live;
    logic [CNT_W-1:0]  free;
  } alloc_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_operation = '0;
  logic [ENT_W-1:0]    in_entity = '0;
  logic [MASK_W-1:0]   in_mask_bits = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CNT_W-1:0]    out_result_entity;
  logic [MASK_W-1:0]   out_mask_out;
  logic [STATUS_W-1:0] out_status;
  logic [CNT_W-1:0]    out_live_count;
  logic [CNT_W-1:0]    out_free_count;

  entity_id_allocator_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_entity         (in_entity),
    .in_mask_bits      (in_mask_bits),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_entity (out_result_entity),
    .out_mask_out      (out_mask_out),
    .out_status        (out_status),
    .out_live_count    (out_live_count),
    .out_free_count    (out_free_count)
  );

  // Shadow copy of the allocator state.
  logic [ENT_W-1:0]  shadow_ring [ENTITY_COUNT];
  logic [ENT_W-1:0]  shadow_head;
  logic [ENT_W-1:0]  shadow_tail;
  int                shadow_live;
  logic [MASK_W-1:0] shadow_masks [ENTITY_COUNT];
  bit                shadow_alive [ENTITY_COUNT];

  alloc_result_t awaited_results[$];

  int  fail_count;
  int  words_checked;
  int  creates_granted;
  int  creates_refused;
  int  stale_destroys;
  int  long_hold_left;
  bit  send_gaps_on = 1'b1;
  bit  recv_gaps_on = 1'b1;

  // Clock.
  initial begin
    forever #4 clk = ~clk;
  end

  // Works out the result of one command and updates the shadow state.
  function automatic alloc_result_t apply_command(logic [OP_W-1:0] op,
                                                  logic [ENT_W-1:0] ent,
                                                  logic [MASK_W-1:0] bits);
    alloc_result_t r;
    logic [ENT_W-1:0] id;
    r.result_entity = '0;
    r.mask = '0;
    r.status = ST_OK;
    case (op)
      OP_CREATE: begin
        if (shadow_live >= ENTITY_COUNT) begin
          r.result_entity = CNT_W'(ENTITY_COUNT);
          r.status = ST_FULL;
          creates_refused++;
        end else begin
          id = shadow_ring[shadow_head];
          shadow_head = shadow_head + 1'b1;
          shadow_live++;
          shadow_alive[id] = 1'b1;
          r.result_entity = CNT_W'(id);
          r.mask = shadow_masks[id];
          creates_granted++;
        end
      end
      OP_DESTROY: begin
        if (!shadow_alive[ent]) begin
          r.status = ST_NOT_LIVE;
          r.mask = shadow_masks[ent];
          stale_destroys++;
        end else begin
          shadow_masks[ent] = '0;
          shadow_alive[ent] = 1'b0;
          shadow_ring[shadow_tail] = ent;
          shadow_tail = shadow_tail + 1'b1;
          shadow_live--;
        end
      end
      OP_SET: begin
        shadow_masks[ent] = shadow_masks[ent] | bits;
        r.mask = shadow_masks[ent];
      end
      OP_CLEAR: begin
        shadow_masks[ent] = shadow_masks[ent] & ~bits;
        r.mask = shadow_masks[ent];
      end
      OP_READ: begin
        r.mask = shadow_masks[ent];
      end
      default: begin
      end
    endcase
    r.live = CNT_W'(shadow_live);
    r.free = CNT_W'(ENTITY_COUNT - shadow_live);
    return r;
  endfunction

  // Offers one word and waits until the block takes it.
  task automatic send_word(logic [OP_W-1:0] op, logic [ENT_W-1:0] ent,
                           logic [MASK_W-1:0] bits);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_entity    <= ent;
    in_mask_bits <= bits;
    do @(posedge clk); while (in_stall !== 1'b0);
    awaited_results.insert(awaited_results.size(), apply_command(op, ent, bits));
    // Random gap before the next word.
    if (send_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drops valid when the sender has nothing more to offer for now.
  task automatic quiet_input();
    if (in_valid) in_valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Picks a live entity when one exists, else any entity.
  function automatic logic [ENT_W-1:0] pick_live_entity();
    logic [ENT_W-1:0] cand;
    cand = ENT_W'($urandom);
    if (shadow_live == 0) return cand;
    for (int i = 0; i < ENTITY_COUNT; i++) begin
      if (shadow_alive[cand]) return cand;
      cand = cand + 1'b1;
    end
    return cand;
  endfunction

  task automatic compare_field(string name, logic [MASK_W-1:0] want,
                               logic [MASK_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s wrong, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Result side: checks each accepted word and drives stall in bursts.
  initial begin
    alloc_result_t want;
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual entity %0d mask %h",
                   $time, out_result_entity, out_mask_out);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("result_entity", MASK_W'(want.result_entity),
                        MASK_W'(out_result_entity));
          compare_field("mask_out", want.mask, out_mask_out);
          compare_field("status", MASK_W'(want.status), MASK_W'(out_status));
          compare_field("live_count", MASK_W'(want.live), MASK_W'(out_live_count));
          compare_field("free_count", MASK_W'(want.free), MASK_W'(out_free_count));
          words_checked++;
        end
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (recv_gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("entity_id_allocator_top: mismatch");
        $finish;
      end
    end
  end

  // Mask operations on free entities, stale destroys, first creates and
  // the unused operation codes.
  task automatic test_directed();
    send_word(OP_READ, 10'd0, 32'h0);
    send_word(OP_SET, 10'd1023, 32'hFFFF_FFFF);
    send_word(OP_CLEAR, 10'd1023, 32'h0000_FFFF);
    send_word(OP_DESTROY, 10'd5, 32'hFFFF_FFFF);
    send_word(OP_DESTROY, 10'd1023, 32'h0);
    send_word(OP_CREATE, 10'd0, 32'h0);
    send_word(OP_CREATE, 10'd1023, 32'hFFFF_FFFF);
    send_word(OP_SET, 10'd1, 32'h8000_0001);
    send_word(OP_SET, 10'd1, 32'h0000_F0F0);
    send_word(OP_CLEAR, 10'd1, 32'h0000_0001);
    send_word(OP_READ, 10'd1, 32'h0);
    send_word(OP_CLEAR, 10'd1, 32'hFFFF_FFFF);
    send_word(OP_SET, 10'd1, 32'h0F0F_0000);
    send_word(OP_DESTROY, 10'd1, 32'h0);
    send_word(OP_DESTROY, 10'd1, 32'h0);
    send_word(OP_CREATE, 10'd0, 32'h0);
    for (logic [OP_W-1:0] op = OP_RESV_FIRST; op <= OP_RESV_LAST; op++) begin
      send_word(op, 10'd1023, 32'hFFFF_FFFF);
      if (op == OP_RESV_LAST) break;
    end
    send_word(OP_READ, 10'd1023, 32'h0);
    send_word(OP_DESTROY, 10'd0, 32'h0);
    send_word(OP_SET, 10'd0, 32'h1234_5678);
    quiet_input();
  endtask

  // Creates until every ID is live, then asks for more; recycled IDs come
  // back with their stored masks.
  task automatic test_fill_to_full();
    while (shadow_live < ENTITY_COUNT) send_word(OP_CREATE, ENT_W'($urandom), $urandom);
    repeat (3) send_word(OP_CREATE, ENT_W'($urandom), $urandom);
    send_word(OP_DESTROY, 10'd512, 32'h0);
    send_word(OP_CREATE, 10'd0, 32'h0);
    send_word(OP_CREATE, 10'd0, 32'h0);
    quiet_input();
  endtask

  // Random mix of commands, mostly aimed at live entities.
  task automatic test_random_churn(int count, int create_pct, int destroy_pct);
    logic [OP_W-1:0]   op;
    logic [ENT_W-1:0]  ent;
    logic [MASK_W-1:0] bits;
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < create_pct) op = OP_CREATE;
      else if (roll < create_pct + destroy_pct) op = OP_DESTROY;
      else begin
        roll = $urandom_range(0, 19);
        if (roll < 7) op = OP_SET;
        else if (roll < 13) op = OP_CLEAR;
        else if (roll < 18) op = OP_READ;
        else op = OP_W'($urandom_range(OP_RESV_FIRST, OP_RESV_LAST));
      end
      if ($urandom_range(0, 99) < (op == OP_DESTROY ? 85 : 60))
        ent = pick_live_entity();
      else
        ent = ENT_W'($urandom);
      bits = $urandom_range(0, 2) == 0 ? ($urandom & $urandom) : $urandom;
      send_word(op, ent, bits);
    end
    quiet_input();
  endtask

  // The receiver holds off for a long stretch while words keep coming, so
  // the queue fills and the input stalls.
  task automatic test_backpressure();
    long_hold_left = LONG_HOLD;
    send_gaps_on = 1'b0;
    for (int n = 0; n < 24; n++) begin
      send_word(n % 3 == 0 ? OP_CREATE : OP_READ, pick_live_entity(), $urandom);
    end
    send_gaps_on = 1'b1;
    quiet_input();
  endtask

  // The sender waits for every result before going on.
  task automatic test_drain_pause();
    wait_for_drain();
    send_word(OP_READ, pick_live_entity(), 32'h0);
    send_word(OP_DESTROY, pick_live_entity(), 32'h0);
    quiet_input();
    wait_for_drain();
  endtask

  initial begin
    for (int i = 0; i < ENTITY_COUNT; i++) begin
      shadow_ring[i]  = ENT_W'(i);
      shadow_masks[i] = '0;
      shadow_alive[i] = 1'b0;
    end
    shadow_head = '0;
    shadow_tail = '0;
    shadow_live = 0;
    fail_count = 0;
    words_checked = 0;
    creates_granted = 0;
    creates_refused = 0;
    stale_destroys = 0;
    long_hold_left = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fill_to_full();
    test_random_churn(80, 10, 55);
    test_backpressure();
    test_drain_pause();
    test_random_churn(70, 50, 15);
    // Last stretch runs at full rate on both sides.
    send_gaps_on = 1'b0;
    recv_gaps_on = 1'b0;
    test_random_churn(70, 30, 30);

    wait_for_drain();
    repeat (10) @(posedge clk);
    $display("Checked %0d result words: %0d IDs handed out, %0d creates refused as full,",
             words_checked, creates_granted, creates_refused);
    $display("%0d destroys of entities that were not live, with long back pressure.",
             stale_destroys);
    if (fail_count == 0) begin
      $display("entity_id_allocator_top: match");
    end else begin
      $display("entity_id_allocator_top: mismatch");
    end
    $finish;
  end

endmodule
